FILE: rtl/sgd_pkg.sv
// Package for the silence gate detector: field and stream widths, register
// indexes and reset values, event kind codes and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package sgd_pkg;

    localparam int POS_W       = 32;
    localparam int LEVEL_W     = 7;
    localparam int FRAMES_W    = 6;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Input tdata: frame_position, frame_level, one pad bit.
    localparam int IN_TDATA_W  = 40;
    // Output tdata: point_or_start, segment_end. The event kind travels in tuser.
    localparam int OUT_TDATA_W = 64;

    localparam int DEFAULT_MAX_WINDOW = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_FRAMES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FRAMES = 2'd3;

    // Register values after reset.
    localparam logic [LEVEL_W-1:0]  RST_ATTACK_LEVEL   = 7'd5;
    localparam logic [FRAMES_W-1:0] RST_ATTACK_FRAMES  = 6'd2;
    localparam logic [LEVEL_W-1:0]  RST_RELEASE_LEVEL  = 7'd2;
    localparam logic [FRAMES_W-1:0] RST_RELEASE_FRAMES = 6'd5;

    // Event kinds.
    localparam logic [KIND_W-1:0] KIND_AUDIO_START   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SILENCE_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEGMENT       = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  point;
        logic [POS_W-1:0]  seg_end;
        logic              last;
    } t_result;

endpackage

FILE: rtl/silence_gate_detector.sv
// Silence gate detector top level: attack/release detection over frame peaks.
// Depends on sgd_pkg and sgd_ram.
`timescale 1ns / 1ps

// Usage
// The input stream carries one word per video frame: tdata holds the frame
// position and its peak level, tuser flags the first frame of a clip and
// tlast the last frame of a clip. Each input word causes zero, one or two
// result words on the output stream: tuser gives the event kind (audio start
// split, silence start split or closed audio segment), tdata the positions,
// and tlast marks the final result of an input word. Thresholds and frame
// counts are to be written by the user over the plain write port only while
// the block is idle; the block itself does not enforce this. Sequence: a word
// is taken, a one-bit-per-cycle remainder unit finds the position modulo the
// window size, the level is written, the S window entries are walked through
// the level memory read port and its registered read, and results are formed
// before the next word is accepted; S = max(attack, release frames) + 1
// capped at MAX_WINDOW. A first-of-clip word adds a clearing pass over all
// MAX_WINDOW entries of the level memory. Results sit in a two-word output
// queue, so the next input word is taken while results wait; if the receiver
// stalls, the block holds in its final step until there is room. After reset
// the block clears the level memory before it accepts input; configuration
// writes are taken at any time.
module silence_gate_detector
    import sgd_pkg::*;
#(
    parameter int MAX_WINDOW = DEFAULT_MAX_WINDOW
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // frame_position[31:0], frame_level[38:32]
    input  logic                   s_axis_tuser,   // first_of_clip
    input  logic                   s_axis_tlast,   // last_of_clip
    // Output stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // point_or_start[31:0], segment_end[63:32]
    output logic [KIND_W-1:0]      m_axis_tuser,   // event_kind[1:0]
    output logic                   m_axis_tlast    // last_of_run
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int SW     = $clog2(MAX_WINDOW + 1);
    localparam int SFW    = (SW > FRAMES_W + 1) ? SW : FRAMES_W + 1;
    localparam int DCNT_W = $clog2(POS_W);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_SCAN = 3'd4;
    localparam logic [2:0] ST_CALC = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ATK  = 2'd1;
    localparam logic [1:0] MODE_REL  = 2'd2;

    // Configuration registers.
    logic [LEVEL_W-1:0]  r_atk_lvl;
    logic [FRAMES_W-1:0] r_atk_frm;
    logic [LEVEL_W-1:0]  r_rel_lvl;
    logic [FRAMES_W-1:0] r_rel_frm;

    // Control and gate state.
    logic [2:0]          r_state, n_state;
    logic                r_item;
    logic [1:0]          r_mode;
    logic                r_atk_act;
    logic                r_rel_act;
    logic                r_open;
    logic [POS_W-1:0]    r_seg;
    logic [POS_W-1:0]    r_clip;

    // Current item.
    logic [POS_W-1:0]    r_pos;
    logic [LEVEL_W-1:0]  r_lvl;
    logic                r_last;

    // Clearing pass and remainder unit.
    logic [AW-1:0]       r_clr;
    logic [SW-1:0]       r_rem;
    logic [POS_W-1:0]    r_sh;
    logic [DCNT_W-1:0]   r_dcnt;

    // Window walk.
    logic [SW-1:0]       r_k;
    logic [AW-1:0]       r_addr;
    logic                r_dv;
    logic [SW-1:0]       r_dk;
    logic [SW-1:0]       r_cnt;
    logic [SW-1:0]       r_back;

    // Result forming.
    logic [POS_W-1:0]    r_st;
    logic                r_pos_gt;
    logic [POS_W-1:0]    r_pos_inc;
    logic                r_att_fire;
    logic                r_rel_fire;

    // Output queue, two words deep.
    t_result             r_fq [2];
    logic                r_fwp;
    logic                r_frp;
    logic [1:0]          r_fcnt;

    // Window size S = max(attack_frames, release_frames) + 1, capped.
    logic [FRAMES_W-1:0] w_frm_max;
    logic [SFW-1:0]      w_s_full;
    logic [SW-1:0]       w_s;
    logic [SW-1:0]       w_s_m1;

    assign w_frm_max = (r_atk_frm > r_rel_frm) ? r_atk_frm : r_rel_frm;
    assign w_s_full  = SFW'(w_frm_max) + SFW'(1);
    assign w_s       = (w_s_full > SFW'(MAX_WINDOW)) ? SW'(MAX_WINDOW) : SW'(w_s_full);
    assign w_s_m1    = w_s - SW'(1);

    // One restoring step of position modulo S per cycle.
    logic [SW:0]   w_trial;
    logic [SW:0]   w_diff;
    logic          w_ge;
    logic [SW-1:0] w_rem_next;
    logic [AW-1:0] w_wp;

    assign w_trial    = {r_rem, r_sh[POS_W-1]};
    assign w_diff     = w_trial - {1'b0, w_s};
    assign w_ge       = (w_trial >= {1'b0, w_s});
    assign w_rem_next = w_ge ? w_diff[SW-1:0] : w_trial[SW-1:0];
    assign w_wp       = r_rem[AW-1:0];

    // Level memory.
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [LEVEL_W-1:0]  w_wdata;
    logic [LEVEL_W-1:0]  w_rdata;
    logic                w_issue;
    logic                w_hit;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        if (r_state == ST_CLR) begin
            w_we = 1'b1;
        end else if (r_state == ST_WR) begin
            w_we    = 1'b1;
            w_waddr = w_wp;
            w_wdata = r_lvl;
        end
    end

    sgd_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (MAX_WINDOW)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_issue = (r_state == ST_SCAN) && (r_k < w_s);
    // An attack counts loud entries, a release counts quiet ones.
    assign w_hit   = (r_mode == MODE_ATK) ? (w_rdata > r_atk_lvl) : (w_rdata < r_rel_lvl);

    // Backdated attack start; a borrow means it falls before frame zero.
    logic [POS_W:0] w_sub;
    assign w_sub = {1'b0, r_pos} - (POS_W + 1)'(r_back);

    // Final step: new gate state and up to two result words.
    logic             w_st_gt;
    logic [POS_W-1:0] w_st;
    logic             w_new_atk;
    logic             w_new_open;
    logic [POS_W-1:0] w_new_seg;
    t_result          w_res [2];
    logic [1:0]       w_nres;
    logic             w_space;
    logic             w_push;
    logic             w_pop;

    assign w_st_gt    = (r_st > r_clip);
    assign w_st       = w_st_gt ? r_st : r_clip;
    assign w_new_atk  = r_att_fire ? 1'b1 : (r_rel_fire ? 1'b0 : r_atk_act);
    assign w_new_open = r_att_fire ? 1'b1 : (r_rel_fire ? 1'b0 : r_open);
    assign w_new_seg  = r_att_fire ? w_st : (r_rel_fire ? '0 : r_seg);

    always_comb begin
        w_res[0] = '0;
        w_res[1] = '0;
        w_nres   = 2'd0;
        // A split at or before the clip start is dropped.
        if (r_att_fire && w_st_gt) begin
            w_res[0] = '{kind: KIND_AUDIO_START, point: w_st, seg_end: '0, last: 1'b0};
            w_nres   = 2'd1;
        end
        if (r_rel_fire) begin
            if (r_open) begin
                w_res[w_nres[0]] = '{kind: KIND_SEGMENT, point: r_seg, seg_end: r_pos,
                                     last: 1'b0};
                w_nres = w_nres + 2'd1;
            end
            if (r_pos_gt) begin
                w_res[w_nres[0]] = '{kind: KIND_SILENCE_START, point: r_pos, seg_end: '0,
                                     last: 1'b0};
                w_nres = w_nres + 2'd1;
            end
        end
        if (r_last && w_new_atk && w_new_open && (w_nres < 2'd2)) begin
            w_res[w_nres[0]] = '{kind: KIND_SEGMENT, point: w_new_seg, seg_end: r_pos_inc,
                                 last: 1'b0};
            w_nres = w_nres + 2'd1;
        end
        // The upper count bit selects the final word: one word sits in slot
        // zero, two words end in slot one.
        if (w_nres != 2'd0) begin
            w_res[w_nres[1]].last = 1'b1;
        end
    end

    assign w_space = (({1'b0, r_fcnt} + {1'b0, w_nres}) <= 3'd2);
    assign w_push  = (r_state == ST_FIN) && w_space;
    assign w_pop   = m_axis_tvalid && m_axis_tready;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = s_axis_tuser ? ST_CLR : ST_DIV;
                end
            end
            ST_CLR: begin
                if (r_clr == AW'(MAX_WINDOW - 1)) begin
                    n_state = r_item ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (r_dcnt == DCNT_W'(POS_W - 1)) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (!w_issue && !r_dv) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_space) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atk_lvl <= RST_ATTACK_LEVEL;
            r_atk_frm <= RST_ATTACK_FRAMES;
            r_rel_lvl <= RST_RELEASE_LEVEL;
            r_rel_frm <= RST_RELEASE_FRAMES;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ATTACK_LEVEL:   r_atk_lvl <= i_cfg_wdata[LEVEL_W-1:0];
                REG_ATTACK_FRAMES:  r_atk_frm <= i_cfg_wdata[FRAMES_W-1:0];
                REG_RELEASE_LEVEL:  r_rel_lvl <= i_cfg_wdata[LEVEL_W-1:0];
                REG_RELEASE_FRAMES: r_rel_frm <= i_cfg_wdata[FRAMES_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_item    <= 1'b0;
            r_clr     <= '0;
            r_dv      <= 1'b0;
            r_mode    <= MODE_NONE;
            r_atk_act <= 1'b0;
            r_rel_act <= 1'b0;
            r_open    <= 1'b0;
            r_seg     <= '0;
            r_clip    <= '0;
            r_fwp     <= 1'b0;
            r_frp     <= 1'b0;
            r_fcnt    <= 2'd0;
        end else begin
            r_state <= n_state;

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_item <= 1'b1;
                        r_pos  <= s_axis_tdata[POS_W-1:0];
                        r_lvl  <= s_axis_tdata[POS_W +: LEVEL_W];
                        r_last <= s_axis_tlast;
                        r_rem  <= '0;
                        r_sh   <= s_axis_tdata[POS_W-1:0];
                        r_dcnt <= '0;
                        r_clr  <= '0;
                        // A new clip starts with a quiet window and no segment.
                        if (s_axis_tuser) begin
                            r_atk_act <= 1'b0;
                            r_rel_act <= 1'b0;
                            r_open    <= 1'b0;
                            r_seg     <= '0;
                            r_clip    <= s_axis_tdata[POS_W-1:0];
                        end
                    end
                end
                ST_CLR: begin
                    r_clr <= r_clr + AW'(1);
                end
                ST_DIV: begin
                    r_rem  <= w_rem_next;
                    r_sh   <= r_sh << 1;
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                end
                ST_WR: begin
                    r_k    <= '0;
                    r_cnt  <= '0;
                    r_back <= '0;
                    r_dv   <= 1'b0;
                    priority if ((r_lvl >= r_atk_lvl) && !r_atk_act) begin
                        r_mode <= MODE_ATK;
                        r_addr <= w_wp;
                    end else if ((r_lvl < r_rel_lvl) && !r_rel_act) begin
                        r_mode <= MODE_REL;
                        r_addr <= '0;
                    end else begin
                        r_mode <= MODE_NONE;
                        r_addr <= '0;
                    end
                end
                ST_SCAN: begin
                    // Address k goes out now; its entry comes back next cycle.
                    r_dv <= w_issue;
                    r_dk <= r_k;
                    if (w_issue) begin
                        r_k <= r_k + SW'(1);
                        if (r_mode == MODE_ATK) begin
                            // Walk backward from the newest entry, wrapping at S.
                            r_addr <= (r_addr == '0) ? AW'(w_s_m1) : r_addr - AW'(1);
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                    if (r_dv && w_hit && (r_mode != MODE_NONE)) begin
                        r_cnt  <= r_cnt + SW'(1);
                        r_back <= r_dk + SW'(1);
                    end
                end
                ST_CALC: begin
                    r_st       <= w_sub[POS_W] ? '0 : w_sub[POS_W-1:0];
                    r_pos_gt   <= (r_pos > r_clip);
                    r_pos_inc  <= r_pos + POS_W'(1);
                    r_att_fire <= (r_mode == MODE_ATK) && (SFW'(r_cnt) >= SFW'(r_atk_frm));
                    r_rel_fire <= (r_mode == MODE_REL) && (SFW'(r_cnt) >= SFW'(r_rel_frm));
                end
                ST_FIN: begin
                    if (w_space) begin
                        r_item    <= 1'b0;
                        r_atk_act <= w_new_atk;
                        r_rel_act <= r_att_fire ? 1'b0 : (r_rel_fire ? 1'b1 : r_rel_act);
                        r_open    <= w_new_open;
                        r_seg     <= w_new_seg;
                    end
                end
                default: begin
                end
            endcase

            // Output queue bookkeeping.
            if (w_push && (w_nres != 2'd0)) begin
                r_fq[r_fwp] <= w_res[0];
                if (w_nres == 2'd2) begin
                    r_fq[~r_fwp] <= w_res[1];
                end
                r_fwp <= r_fwp ^ w_nres[0];
            end
            if (w_pop) begin
                r_frp <= ~r_frp;
            end
            r_fcnt <= r_fcnt + (w_push ? w_nres : 2'd0) - {1'b0, w_pop};
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_fcnt != 2'd0);
    assign m_axis_tdata  = {r_fq[r_frp].seg_end, r_fq[r_frp].point};
    assign m_axis_tuser  = r_fq[r_frp].kind;
    assign m_axis_tlast  = r_fq[r_frp].last;

    // The output queue never holds more than its two words.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= 2'd2)
        else $error("output queue overfilled");

    // The remainder unit leaves a write slot inside the window.
    a_rem_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> (r_rem < w_s))
        else $error("window slot outside window size");

    // Every walked address lies inside the window.
    a_scan_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (SW'(r_addr) < w_s))
        else $error("window walk address out of range");

    // The gate is never in attack and released at once.
    a_gate_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_atk_act && r_rel_act))
        else $error("attack and release both active");

    // An open segment only exists while the gate is in attack.
    a_open_in_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> r_atk_act)
        else $error("segment open outside attack");

endmodule

FILE: rtl/sgd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module sgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
